@@ rtl/smwf_pkg.sv @@
// Shared constants, types and the message type length table for the word framer.
package smwf_pkg;

    localparam int QUEUE_SLOTS = 4;
    localparam int SLOT_SIZE   = 20;
    localparam int WORD_BYTES  = 4;
    localparam int SLOT_WORDS  = (SLOT_SIZE + WORD_BYTES - 1) / WORD_BYTES;
    localparam int RAM_DEPTH   = QUEUE_SLOTS * SLOT_WORDS;
    localparam int ADDR_W      = $clog2(RAM_DEPTH);
    localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
    localparam int COUNT_W     = $clog2(QUEUE_SLOTS + 1);
    localparam int FILL_W      = $clog2(SLOT_SIZE + 1);
    localparam int LEN_W       = 5;
    localparam int SOFF_W      = LEN_W + 1;
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;

    localparam logic [WORD_W-1:0] SYNC_RESET = 32'hDEADBEEF;

    localparam logic OP_EXCHANGE = 1'b0;
    localparam logic OP_LOAD     = 1'b1;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] rx_word;
        logic [BYTE_W-1:0] msg_byte;
        logic              msg_last;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] queued_messages;
        logic               load_refused;
        logic               rx_valid;
        logic [WORD_W-1:0]  rx_out;
        logic [WORD_W-1:0]  tx_word;
    } result_t;

    function automatic logic [LEN_W-1:0] type_len(input logic [BYTE_W-1:0] msg_type);
        logic [LEN_W-1:0] len;
        unique case (msg_type)
            8'd1:    len = LEN_W'(3);
            8'd3:    len = LEN_W'(1);
            8'd5:    len = LEN_W'(12);
            8'd6:    len = LEN_W'(18);
            8'd8:    len = LEN_W'(17);
            default: len = '0;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/smwf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module smwf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/smwf_core.sv @@
// Message queue state, slot RAM and per-item read-modify-write execution.
module smwf_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       exec,
    input  smwf_pkg::item_t            item,
    input  logic [smwf_pkg::WORD_W-1:0] sync_word,
    output smwf_pkg::result_t          result
);
    import smwf_pkg::*;

    logic               synced_reg,   synced_next;
    logic [SLOT_W-1:0]  head_reg,     head_next;
    logic [COUNT_W-1:0] count_reg,    count_next;
    logic [SOFF_W-1:0]  send_off_reg, send_off_next;
    logic               len_sent_reg, len_sent_next;
    logic [FILL_W-1:0]  load_off_reg, load_off_next;
    logic               discard_reg,  discard_next;
    logic [WORD_W-1:0]  stage_reg,    stage_next;

    logic [FILL_W-1:0]  fill_reg [QUEUE_SLOTS];
    logic [LEN_W-1:0]   slen_reg [QUEUE_SLOTS];
    logic               fill_we;
    logic [FILL_W-1:0]  fill_next;
    logic               slen_we;
    logic [LEN_W-1:0]   slen_next;

    logic [COUNT_W-1:0] tail_sum;
    logic [SLOT_W-1:0]  tail_idx;
    logic [FILL_W-1:0]  head_fill;
    logic [LEN_W-1:0]   head_len;
    logic [1:0]         lane;
    logic [LEN_W-1:0]   byte_len;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic [WORD_W-1:0]  packed_word;

    assign tail_sum  = COUNT_W'(head_reg) + count_reg;
    assign tail_idx  = (tail_sum >= COUNT_W'(QUEUE_SLOTS)) ?
                       SLOT_W'(tail_sum - COUNT_W'(QUEUE_SLOTS)) : SLOT_W'(tail_sum);
    assign head_fill = fill_reg[head_reg];
    assign head_len  = slen_reg[head_reg];
    assign lane      = load_off_reg[1:0];
    assign byte_len  = type_len(item.msg_byte);

    assign rd_addr = ADDR_W'(int'(head_reg) * SLOT_WORDS + int'(send_off_reg >> 2));
    assign wr_addr = ADDR_W'(int'(tail_idx) * SLOT_WORDS + int'(load_off_reg >> 2));

    smwf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (stage_next),
        .rd_en   (start),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        logic [SOFF_W:0] boff;
        for (int j = 0; j < WORD_BYTES; j++)
        begin
            boff = (SOFF_W+1)'(send_off_reg) + (SOFF_W+1)'(j);
            if (boff < (SOFF_W+1)'(head_fill))
            begin
                packed_word[WORD_W-1-BYTE_W*j -: BYTE_W] = rd_data[BYTE_W*j +: BYTE_W];
            end
            else
            begin
                packed_word[WORD_W-1-BYTE_W*j -: BYTE_W] = '0;
            end
        end
    end

    always_comb
    begin
        synced_next   = synced_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        send_off_next = send_off_reg;
        len_sent_next = len_sent_reg;
        load_off_next = load_off_reg;
        discard_next  = discard_reg;
        stage_next    = stage_reg;
        fill_we       = 1'b0;
        fill_next     = '0;
        slen_we       = 1'b0;
        slen_next     = byte_len;
        wr_en         = 1'b0;
        result        = '0;

        if (exec)
        begin
            if (item.op == OP_LOAD)
            begin
                if (discard_reg)
                begin
                    result.load_refused = 1'b1;
                    if (item.msg_last)
                    begin
                        discard_next = 1'b0;
                    end
                end
                else if (load_off_reg == '0 &&
                         (count_reg >= COUNT_W'(QUEUE_SLOTS) || byte_len == '0))
                begin
                    result.load_refused = 1'b1;
                    if (!item.msg_last)
                    begin
                        discard_next = 1'b1;
                    end
                end
                else
                begin
                    if (load_off_reg == '0)
                    begin
                        slen_we = 1'b1;
                        fill_we = 1'b1;
                    end
                    if (load_off_reg < FILL_W'(SLOT_SIZE))
                    begin
                        stage_next = (lane == 2'd0) ? '0 : stage_reg;
                        stage_next[BYTE_W*lane +: BYTE_W] = item.msg_byte;
                        wr_en         = 1'b1;
                        fill_we       = 1'b1;
                        fill_next     = load_off_reg + FILL_W'(1);
                        load_off_next = load_off_reg + FILL_W'(1);
                    end
                    else
                    begin
                        result.load_refused = 1'b1;
                    end
                    if (item.msg_last)
                    begin
                        count_next    = count_reg + COUNT_W'(1);
                        load_off_next = '0;
                    end
                end
            end
            else if (!synced_reg)
            begin
                if (item.rx_word == sync_word)
                begin
                    synced_next = 1'b1;
                end
            end
            else
            begin
                if (count_reg != '0)
                begin
                    if (!len_sent_reg)
                    begin
                        result.tx_word = WORD_W'(head_len);
                        len_sent_next  = 1'b1;
                    end
                    else if (send_off_reg < SOFF_W'(head_len))
                    begin
                        result.tx_word = packed_word;
                        send_off_next  = send_off_reg + SOFF_W'(WORD_BYTES);
                    end
                    else
                    begin
                        count_next    = count_reg - COUNT_W'(1);
                        head_next     = (head_reg == SLOT_W'(QUEUE_SLOTS - 1)) ?
                                        '0 : head_reg + SLOT_W'(1);
                        send_off_next = '0;
                        len_sent_next = 1'b0;
                    end
                end
                result.rx_out   = item.rx_word;
                result.rx_valid = 1'b1;
            end
        end
        result.queued_messages = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg   <= 1'b0;
            head_reg     <= '0;
            count_reg    <= '0;
            send_off_reg <= '0;
            len_sent_reg <= 1'b0;
            load_off_reg <= '0;
            discard_reg  <= 1'b0;
            for (int i = 0; i < QUEUE_SLOTS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            synced_reg   <= synced_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            send_off_reg <= send_off_next;
            len_sent_reg <= len_sent_next;
            load_off_reg <= load_off_next;
            discard_reg  <= discard_next;
            if (fill_we)
            begin
                fill_reg[tail_idx] <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
        if (slen_we)
        begin
            slen_reg[tail_idx] <= slen_next;
        end
    end

endmodule

@@ rtl/serial_message_word_framer.sv @@
// Top level of the serial message word framer: stream handshake, sync register, result register.
//
// Each input transfer has a read step, which fetches the head slot word from the slot RAM, then
// the execute step: exchange or byte load and result register write. A new input transfer is
// taken while the previous result still waits on the output side; the execute step then holds
// until the result register is free. After reset no clearing pass is needed: per-slot fill
// counts mask bytes that were never loaded, so the block accepts input at once.
module serial_message_word_framer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sync_wr_en,
    input  logic [31:0] sync_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // rx_word[31:0], msg_byte[39:32]
    input  logic        s_tuser,   // op
    input  logic        s_tlast,   // msg_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // tx_word[31:0], rx_out[63:32], rx_valid[64],
                                   // load_refused[65], queued_messages[68:66]
);
    import smwf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [WORD_W-1:0] sync_reg;
    item_t             item_reg;
    result_t           result;
    logic [71:0]       tdata_reg;
    logic              tvalid_reg, tvalid_next;
    logic              start;
    logic              exec;

    assign s_tready = (state_reg == ST_IDLE);
    assign start    = s_tvalid && s_tready;
    assign exec     = (state_reg == ST_EXEC) && (!tvalid_reg || m_tready);
    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;

    smwf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .exec      (exec),
        .item      (item_reg),
        .sync_word (sync_reg),
        .result    (result)
    );

    always_comb
    begin
        state_next  = state_reg;
        tvalid_next = tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec)
                begin
                    state_next  = ST_IDLE;
                    tvalid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tvalid_reg <= 1'b0;
            sync_reg   <= SYNC_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            tvalid_reg <= tvalid_next;
            if (sync_wr_en)
            begin
                sync_reg <= sync_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg.op       <= s_tuser;
            item_reg.rx_word  <= s_tdata[31:0];
            item_reg.msg_byte <= s_tdata[39:32];
            item_reg.msg_last <= s_tlast;
        end
        if (exec)
        begin
            tdata_reg <= {3'b000, result.queued_messages, result.load_refused, result.rx_valid,
                          result.rx_out, result.tx_word};
        end
    end

endmodule

@@ test/serial_message_word_framer_tb.sv @@
// Self-checking testbench for the serial message word framer: directed rows, then random traffic.
module serial_message_word_framer_tb;
    import smwf_pkg::*;

    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 285;
    localparam int TYPE_COUNT  = 10;

    localparam logic [7:0] TYPE_EMPTY   = 8'd0;
    localparam logic [7:0] TYPE_LEN3    = 8'd1;
    localparam logic [7:0] TYPE_LEN1    = 8'd3;
    localparam logic [7:0] TYPE_LEN12   = 8'd5;
    localparam logic [7:0] TYPE_LEN18   = 8'd6;
    localparam logic [7:0] TYPE_LEN17   = 8'd8;
    localparam logic [7:0] TYPE_UNKNOWN = 8'd10;
    localparam logic [7:0] TYPE_MAX     = 8'hFF;

    typedef struct packed {
        item_t   it;
        logic    fixed;
        result_t want;
    } stim_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        sync_wr_en   = 1'b0;
    logic [31:0] sync_wr_data = '0;
    logic        s_tvalid     = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata      = '0;
    logic        s_tuser      = 1'b0;
    logic        s_tlast      = 1'b0;
    logic        m_tvalid;
    logic        m_tready     = 1'b0;
    logic [71:0] m_tdata;

    int msg_len_tab [0:TYPE_COUNT-1] = '{0, 3, 0, 1, 0, 12, 18, 0, 17, 0};
    logic [7:0] good_types [0:4] = '{TYPE_LEN3, TYPE_LEN1, TYPE_LEN12, TYPE_LEN18, TYPE_LEN17};

    logic [31:0] sh_sync_word;
    bit          sh_synced;
    logic [7:0]  sh_slot [0:QUEUE_SLOTS*SLOT_SIZE-1];
    int          sh_head;
    int          sh_count;
    int          sh_send_off;
    bit          sh_len_sent;
    int          sh_load_off;
    bit          sh_discard;

    stim_t   plan_q [$];
    result_t owed_words [$];

    bit quiet     = 1'b0;
    int hold_req  = 0;
    int errors    = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int n_refused = 0;
    int n_data    = 0;
    int n_full    = 0;
    int n_writes  = 0;

    serial_message_word_framer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sync_wr_en   (sync_wr_en),
        .sync_wr_data (sync_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("[serial_message_word_framer] ERROR");
        $finish;
    end

    function automatic int length_of(logic [7:0] kind);
        return (kind < TYPE_COUNT) ? msg_len_tab[kind] : 0;
    endfunction

    function automatic logic [7:0] head_byte(int off);
        return (off >= SLOT_SIZE) ? 8'h00 : sh_slot[sh_head * SLOT_SIZE + off];
    endfunction

    function automatic void clear_shadow();
        sh_sync_word = SYNC_RESET;
        sh_synced    = 1'b0;
        for (int i = 0; i < QUEUE_SLOTS * SLOT_SIZE; i++)
            sh_slot[i] = 8'h00;
        sh_head     = 0;
        sh_count    = 0;
        sh_send_off = 0;
        sh_len_sent = 1'b0;
        sh_load_off = 0;
        sh_discard  = 1'b0;
    endfunction

    function automatic logic queue_byte(logic [7:0] b, logic last);
        int base;
        logic refused;
        refused = 1'b0;
        base = ((sh_head + sh_count) % QUEUE_SLOTS) * SLOT_SIZE;
        if (sh_discard)
        begin
            if (last)
                sh_discard = 1'b0;
            return 1'b1;
        end
        if (sh_load_off == 0)
        begin
            if (sh_count >= QUEUE_SLOTS || length_of(b) == 0)
            begin
                if (!last)
                    sh_discard = 1'b1;
                return 1'b1;
            end
            for (int i = 0; i < SLOT_SIZE; i++)
                sh_slot[base + i] = 8'h00;
        end
        if (sh_load_off < SLOT_SIZE)
        begin
            sh_slot[base + sh_load_off] = b;
            sh_load_off++;
        end
        else
            refused = 1'b1;
        if (last)
        begin
            sh_count++;
            sh_load_off = 0;
        end
        return refused;
    endfunction

    function automatic result_t framer_outcome(item_t it);
        result_t r;
        int len;
        r = '0;
        if (it.op == OP_LOAD)
            r.load_refused = queue_byte(it.msg_byte, it.msg_last);
        else if (!sh_synced)
        begin
            if (it.rx_word == sh_sync_word)
                sh_synced = 1'b1;
        end
        else
        begin
            if (sh_count != 0)
            begin
                len = length_of(head_byte(0));
                if (!sh_len_sent)
                begin
                    r.tx_word = 32'(len);
                    sh_len_sent = 1'b1;
                end
                else if (sh_send_off < len)
                begin
                    r.tx_word = {head_byte(sh_send_off), head_byte(sh_send_off + 1),
                                 head_byte(sh_send_off + 2), head_byte(sh_send_off + 3)};
                    sh_send_off += 4;
                end
                else
                begin
                    sh_count--;
                    sh_head = (sh_head + 1) % QUEUE_SLOTS;
                    sh_send_off = 0;
                    sh_len_sent = 1'b0;
                end
            end
            r.rx_out = it.rx_word;
            r.rx_valid = 1'b1;
        end
        r.queued_messages = COUNT_W'(sh_count);
        return r;
    endfunction

    function automatic void row(logic op, logic [31:0] rx, logic [7:0] b, logic last,
                                logic fixed, logic [31:0] tx, logic [31:0] rxo, logic rxv,
                                logic refused, int cnt);
        stim_t s;
        s.it.op              = op;
        s.it.rx_word         = rx;
        s.it.msg_byte        = b;
        s.it.msg_last        = last;
        s.fixed              = fixed;
        s.want.tx_word       = tx;
        s.want.rx_out        = rxo;
        s.want.rx_valid      = rxv;
        s.want.load_refused  = refused;
        s.want.queued_messages = COUNT_W'(cnt);
        plan_q.push_back(s);
    endfunction

    function automatic void plan_item(logic op, logic [7:0] b, logic last);
        logic [31:0] rx;
        rx = ($urandom_range(0, 15) == 0) ? sh_sync_word : $urandom();
        row(op, rx, b, last, 1'b0, '0, '0, 1'b0, 1'b0, 0);
    endfunction

    function automatic void plan_message();
        logic [7:0] kind;
        int n;
        if ($urandom_range(0, 9) == 0)
            kind = 8'($urandom_range(0, 255));
        else
            kind = good_types[$urandom_range(0, 4)];
        n = length_of(kind);
        case ($urandom_range(0, 9))
            0, 1: n += $urandom_range(1, 6);
            2: n = $urandom_range(1, (n > 0) ? n : 1);
            default: ;
        endcase
        if (n < 1)
            n = 1;
        for (int k = 0; k < n; k++)
        begin
            if (k > 0 && $urandom_range(0, 19) == 0)
                plan_item(OP_EXCHANGE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            plan_item(OP_LOAD, (k == 0) ? kind : 8'($urandom_range(0, 255)), k == n - 1);
        end
    endfunction

    function automatic void plan_random(int n);
        int burst;
        while (plan_q.size() < n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    burst = $urandom_range(1, 3);
                    repeat (burst) plan_message();
                end
                5, 6, 7, 8:
                begin
                    burst = $urandom_range(1, 12);
                    repeat (burst)
                        plan_item(OP_EXCHANGE, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
                end
                default:
                    plan_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            endcase
        end
    endfunction

    function automatic void check_word(result_t got);
        result_t want;
        if (owed_words.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result transfer: %h", got);
            return;
        end
        want = owed_words.pop_front();
        n_checked++;
        if (got.tx_word !== want.tx_word || got.rx_out !== want.rx_out ||
            got.rx_valid !== want.rx_valid || got.load_refused !== want.load_refused ||
            got.queued_messages !== want.queued_messages)
        begin
            errors++;
            if (errors <= 10)
                $display({"mismatch at result %0d: tx %h/%h rx_out %h/%h rx_valid %b/%b ",
                          "refused %b/%b count %0d/%0d (want/got)"},
                         n_checked, want.tx_word, got.tx_word, want.rx_out, got.rx_out,
                         want.rx_valid, got.rx_valid, want.load_refused, got.load_refused,
                         want.queued_messages, got.queued_messages);
        end
    endfunction

    task automatic send_word(stim_t s);
        int gap;
        result_t r;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= s.it.op;
        s_tlast  <= s.it.msg_last;
        s_tdata  <= {s.it.msg_byte, s.it.rx_word};
        do
            @(posedge clk);
        while (!s_tready);
        r = framer_outcome(s.it);
        if (s.fixed)
            r = s.want;
        owed_words.push_back(r);
        n_sent++;
        if (r.load_refused)
            n_refused++;
        if (r.tx_word != 0)
            n_data++;
        if (r.queued_messages == QUEUE_SLOTS)
            n_full++;
    endtask

    task automatic run_plan(int hold_at);
        int idx;
        idx = 0;
        while (plan_q.size() != 0)
        begin
            if (idx == hold_at)
                hold_req++;
            send_word(plan_q.pop_front());
            idx++;
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic write_sync(logic [31:0] value);
        while (owed_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        sync_wr_en   <= 1'b1;
        sync_wr_data <= value;
        @(posedge clk);
        sync_wr_en   <= 1'b0;
        sh_sync_word = value;
        n_writes++;
    endtask

    initial
    begin : rx_side
        int stall;
        int hold_seen;
        stall = 0;
        hold_seen = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_word(result_t'(m_tdata[$bits(result_t)-1:0]));
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                stall = HOLD_CYCLES;
            end
            else if (stall == 0 && !quiet && $urandom_range(0, 7) == 0)
                stall = $urandom_range(1, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : tx_side
        logic [31:0] sync_values [0:3];
        sync_values[0] = 32'h0000_0000;
        sync_values[1] = 32'hFFFF_FFFF;
        sync_values[2] = $urandom();
        sync_values[3] = SYNC_RESET;
        clear_shadow();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        //   op           rx_word       byte          last  fix  tx     rx_out        v  ref cnt
        row(OP_EXCHANGE, 32'h0000_0000, 8'h00,        1'b0, 1, 32'h0, 32'h0,        0, 0, 0);
        row(OP_EXCHANGE, 32'hFFFF_FFFF, 8'hFF,        1'b1, 1, 32'h0, 32'h0,        0, 0, 0);
        row(OP_LOAD,     32'h0000_0000, TYPE_EMPTY,   1'b0, 1, 32'h0, 32'h0,        0, 1, 0);
        row(OP_LOAD,     32'hFFFF_FFFF, 8'hFF,        1'b1, 1, 32'h0, 32'h0,        0, 1, 0);
        row(OP_LOAD,     32'h0000_0000, TYPE_MAX,     1'b1, 1, 32'h0, 32'h0,        0, 1, 0);
        row(OP_LOAD,     32'h0000_0000, TYPE_UNKNOWN, 1'b1, 1, 32'h0, 32'h0,        0, 1, 0);
        row(OP_EXCHANGE, SYNC_RESET,    8'h00,        1'b0, 1, 32'h0, 32'h0,        0, 0, 0);
        row(OP_EXCHANGE, 32'h8000_0001, 8'h00,        1'b0, 1, 32'h0, 32'h8000_0001, 1, 0, 0);
        row(OP_LOAD,     32'h0000_0000, TYPE_LEN1,    1'b0, 0, 32'h0, 32'h0,        0, 0, 0);
        row(OP_LOAD,     32'h0000_0000, 8'hAB,        1'b1, 0, 32'h0, 32'h0,        0, 0, 0);
        row(OP_EXCHANGE, 32'h0000_0001, 8'h00,        1'b0, 0, 32'h0, 32'h0,        0, 0, 0);
        row(OP_EXCHANGE, 32'h0000_0002, 8'h00,        1'b0, 0, 32'h0, 32'h0,        0, 0, 0);
        row(OP_EXCHANGE, 32'h0000_0003, 8'h00,        1'b0, 0, 32'h0, 32'h0,        0, 0, 0);
        row(OP_LOAD,     32'h0000_0000, TYPE_LEN1,    1'b1, 0, 32'h0, 32'h0,        0, 0, 0);
        row(OP_LOAD,     32'h0000_0000, TYPE_LEN3,    1'b1, 0, 32'h0, 32'h0,        0, 0, 0);
        row(OP_LOAD,     32'h0000_0000, TYPE_LEN17,   1'b1, 0, 32'h0, 32'h0,        0, 0, 0);
        row(OP_LOAD,     32'h0000_0000, TYPE_LEN18,   1'b1, 0, 32'h0, 32'h0,        0, 0, 0);
        row(OP_LOAD,     32'h0000_0000, TYPE_LEN12,   1'b1, 1, 32'h0, 32'h0,        0, 1, 4);
        row(OP_LOAD,     32'h0000_0000, TYPE_LEN3,    1'b0, 1, 32'h0, 32'h0,        0, 1, 4);
        row(OP_LOAD,     32'h0000_0000, 8'h55,        1'b1, 1, 32'h0, 32'h0,        0, 1, 4);
        run_plan(-1);

        for (int ph = 0; ph < 4; ph++)
        begin
            write_sync(sync_values[ph]);
            quiet = (ph == 3);
            plan_random(PHASE_ITEMS);
            run_plan((ph == 0 || ph == 2) ? 80 : -1);
        end

        while (owed_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("covered %0d input transfers and %0d checked results over %0d sync word settings",
                 n_sent, n_checked, n_writes);
        $display("refused loads %0d, nonzero tx words %0d, full-queue results %0d",
                 n_refused, n_data, n_full);
        if (errors == 0)
            $display("[serial_message_word_framer] OK");
        else
            $display("[serial_message_word_framer] ERROR");
        $finish;
    end

endmodule
